// ----- design/mtr_pkg.sv -----
package mtr_pkg;

  typedef enum logic [1:0] {
    MODE_ON_DELAY  = 2'd0,
    MODE_OFF_DELAY = 2'd1,
    MODE_BLINK     = 2'd2,
    MODE_PULSE     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_TIMING     = 3'd1,
    PH_ACTIVE     = 3'd2,
    PH_BLINK_OFF  = 3'd3,
    PH_PULSE_WAIT = 3'd4,
    PH_LOCK       = 3'd5
  } phase_t;

  localparam int RegIndexW = 2;
  localparam int RegDataW  = 8;

  localparam logic [RegIndexW-1:0] REG_MODE  = 2'd0;
  localparam logic [RegIndexW-1:0] REG_DELAY = 2'd1;
  localparam logic [RegIndexW-1:0] REG_TPS   = 2'd2;

  localparam logic [7:0] TPS_RESET = 8'd61;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] delay_seconds;
    logic [7:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    logic relay_on;
    logic off_delay_active;
  } result_t;

endpackage

// ----- design/mtr_tick_if.sv -----
interface mtr_tick_if;
  logic valid;
  logic ready;
  logic start_pressed;
  logic stop_pressed;

  modport source (output valid, output start_pressed, output stop_pressed, input ready);
  modport sink (input valid, input start_pressed, input stop_pressed, output ready);
endinterface

// ----- design/mtr_result_if.sv -----
interface mtr_result_if;
  logic valid;
  logic ready;
  logic relay_on;
  logic off_delay_active;

  modport source (output valid, output relay_on, output off_delay_active, input ready);
  modport sink (input valid, input relay_on, input off_delay_active, output ready);
endinterface

// ----- design/mtr_cfg_if.sv -----
interface mtr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mtr_pkg::RegIndexW-1:0] reg_index;
  logic [mtr_pkg::RegDataW-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- design/mtr_debounce.sv -----
module mtr_debounce #(
  parameter int HISTORY_LEN = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic raw,
  output logic level_next
);

  logic [HISTORY_LEN-1:0] hist;
  logic [HISTORY_LEN-1:0] hist_next;
  logic                   level;

  assign hist_next = {hist[HISTORY_LEN-2:0], raw};

  // level follows only once every sample agrees
  always_comb begin
    level_next = level;
    if (&hist_next) begin
      level_next = 1'b1;
    end else if (~|hist_next) begin
      level_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= '0;
      level <= 1'b0;
    end else if (en) begin
      hist  <= hist_next;
      level <= level_next;
    end
  end

endmodule

// ----- design/mtr_ctrl.sv -----
module mtr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             start,
  input  logic             stop,
  input  logic             mode_wr,
  input  mtr_pkg::cfg_t    cfg,
  output mtr_pkg::result_t res_next
);

  mtr_pkg::phase_t phase;
  mtr_pkg::phase_t phase_next;
  logic [7:0]      tick_count;
  logic [7:0]      tick_count_next;
  logic [3:0]      second_count;
  logic [3:0]      second_count_next;
  logic            relay_reg;
  logic            relay_reg_next;
  logic            delay_flag;
  logic            delay_flag_next;

  logic [7:0]      tps_eff;
  logic [8:0]      tick_inc;
  logic [7:0]      adv_tick;
  logic [3:0]      adv_second;
  logic            timed;
  logic [3:0]      second_cur;
  logic            done;

  // prescaler step, a zero rate counts as one tick a second
  always_comb begin
    tps_eff    = (cfg.ticks_per_second == 8'd0) ? 8'd1 : cfg.ticks_per_second;
    tick_inc   = {1'b0, tick_count} + 9'd1;
    adv_tick   = tick_inc[7:0];
    adv_second = second_count;
    if (tick_inc >= {1'b0, tps_eff}) begin
      adv_tick = 8'd0;
      if (second_count < cfg.delay_seconds) begin
        adv_second = second_count + 4'd1;
      end
    end
    timed      = (phase == mtr_pkg::PH_TIMING) || (phase == mtr_pkg::PH_BLINK_OFF);
    second_cur = timed ? adv_second : second_count;
    done       = second_cur >= cfg.delay_seconds;
  end

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    second_count_next = second_count;
    relay_reg_next    = relay_reg;
    delay_flag_next   = delay_flag;

    if (mode_wr) begin
      if (phase != mtr_pkg::PH_LOCK) begin
        phase_next      = mtr_pkg::PH_IDLE;
        relay_reg_next  = 1'b0;
        delay_flag_next = 1'b0;
      end
    end else if (en) begin
      if (stop) begin
        phase_next      = mtr_pkg::PH_LOCK;
        relay_reg_next  = 1'b0;
        delay_flag_next = 1'b0;
      end else if (phase == mtr_pkg::PH_LOCK) begin
        phase_next      = mtr_pkg::PH_IDLE;
        relay_reg_next  = 1'b0;
        delay_flag_next = 1'b0;
      end else begin
        if (timed) begin
          tick_count_next   = adv_tick;
          second_count_next = adv_second;
        end
        case (cfg.mode)
          mtr_pkg::MODE_ON_DELAY: begin
            if (phase == mtr_pkg::PH_IDLE) begin
              if (start) begin
                tick_count_next   = 8'd0;
                second_count_next = 4'd0;
                phase_next        = mtr_pkg::PH_TIMING;
                relay_reg_next    = 1'b0;
              end
            end else if (phase == mtr_pkg::PH_TIMING) begin
              if (!start) begin
                phase_next      = mtr_pkg::PH_IDLE;
                relay_reg_next  = 1'b0;
                delay_flag_next = 1'b0;
              end else if (done) begin
                relay_reg_next = 1'b1;
                phase_next     = mtr_pkg::PH_ACTIVE;
              end
            end else if (phase == mtr_pkg::PH_ACTIVE) begin
              if (!start) begin
                phase_next      = mtr_pkg::PH_IDLE;
                relay_reg_next  = 1'b0;
                delay_flag_next = 1'b0;
              end
            end else begin
              phase_next      = mtr_pkg::PH_IDLE;
              relay_reg_next  = 1'b0;
              delay_flag_next = 1'b0;
            end
          end
          mtr_pkg::MODE_OFF_DELAY: begin
            if (phase == mtr_pkg::PH_IDLE) begin
              if (start) begin
                relay_reg_next = 1'b1;
                phase_next     = mtr_pkg::PH_ACTIVE;
              end
            end else if (phase == mtr_pkg::PH_ACTIVE) begin
              if (!start) begin
                delay_flag_next   = 1'b1;
                tick_count_next   = 8'd0;
                second_count_next = 4'd0;
                phase_next        = mtr_pkg::PH_TIMING;
              end
            end else if (phase == mtr_pkg::PH_TIMING) begin
              // start is ignored until the delay runs out
              if (done) begin
                delay_flag_next = 1'b0;
                if (start) begin
                  relay_reg_next = 1'b1;
                  phase_next     = mtr_pkg::PH_ACTIVE;
                end else begin
                  phase_next     = mtr_pkg::PH_IDLE;
                  relay_reg_next = 1'b0;
                end
              end
            end else begin
              phase_next      = mtr_pkg::PH_IDLE;
              relay_reg_next  = 1'b0;
              delay_flag_next = 1'b0;
            end
          end
          mtr_pkg::MODE_BLINK: begin
            if (phase == mtr_pkg::PH_IDLE) begin
              if (start) begin
                relay_reg_next    = 1'b1;
                tick_count_next   = 8'd0;
                second_count_next = 4'd0;
                phase_next        = mtr_pkg::PH_TIMING;
              end
            end else if (phase == mtr_pkg::PH_TIMING || phase == mtr_pkg::PH_BLINK_OFF) begin
              if (!start) begin
                phase_next      = mtr_pkg::PH_IDLE;
                relay_reg_next  = 1'b0;
                delay_flag_next = 1'b0;
              end else if (done) begin
                tick_count_next   = 8'd0;
                second_count_next = 4'd0;
                if (phase == mtr_pkg::PH_TIMING) begin
                  relay_reg_next = 1'b0;
                  phase_next     = mtr_pkg::PH_BLINK_OFF;
                end else begin
                  relay_reg_next = 1'b1;
                  phase_next     = mtr_pkg::PH_TIMING;
                end
              end
            end else begin
              phase_next      = mtr_pkg::PH_IDLE;
              relay_reg_next  = 1'b0;
              delay_flag_next = 1'b0;
            end
          end
          default: begin
            if (phase == mtr_pkg::PH_IDLE) begin
              if (start) begin
                relay_reg_next    = 1'b1;
                tick_count_next   = 8'd0;
                second_count_next = 4'd0;
                phase_next        = mtr_pkg::PH_TIMING;
              end
            end else if (phase == mtr_pkg::PH_TIMING) begin
              if (!start) begin
                phase_next      = mtr_pkg::PH_IDLE;
                relay_reg_next  = 1'b0;
                delay_flag_next = 1'b0;
              end else if (done) begin
                relay_reg_next = 1'b0;
                phase_next     = mtr_pkg::PH_PULSE_WAIT;
              end
            end else if (phase == mtr_pkg::PH_PULSE_WAIT) begin
              // a new pulse needs a release first
              if (!start) begin
                phase_next      = mtr_pkg::PH_IDLE;
                relay_reg_next  = 1'b0;
                delay_flag_next = 1'b0;
              end
            end else begin
              phase_next      = mtr_pkg::PH_IDLE;
              relay_reg_next  = 1'b0;
              delay_flag_next = 1'b0;
            end
          end
        endcase
      end
    end
  end

  assign res_next.relay_on         = relay_reg_next;
  assign res_next.off_delay_active = delay_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mtr_pkg::PH_IDLE;
      tick_count   <= 8'd0;
      second_count <= 4'd0;
      relay_reg    <= 1'b0;
      delay_flag   <= 1'b0;
    end else begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      second_count <= second_count_next;
      relay_reg    <= relay_reg_next;
      delay_flag   <= delay_flag_next;
    end
  end

  a_flag_only_timing: assert property (@(posedge clk) disable iff (rst)
    delay_flag |-> (phase == mtr_pkg::PH_TIMING && cfg.mode == mtr_pkg::MODE_OFF_DELAY))
    else $error("off-delay flag set outside off-delay timing");

  a_lock_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == mtr_pkg::PH_LOCK) |-> (!relay_reg && !delay_flag))
    else $error("outputs active while locked");

  a_stop_locks: assert property (@(posedge clk) disable iff (rst)
    (en && stop && !mode_wr) |=> (phase == mtr_pkg::PH_LOCK))
    else $error("debounced stop did not lock");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (mode_wr && phase != mtr_pkg::PH_LOCK) |=> (phase == mtr_pkg::PH_IDLE && !relay_reg))
    else $error("mode write did not return to idle");

endmodule

// ----- design/multifunction_time_relay.sv -----
// channel  | dir | handshake      | payload
// tick     | in  | valid / ready  | start_pressed, stop_pressed
// result   | out | valid / ready  | relay_on, off_delay_active
// cfg      | in  | valid / ready  | reg_index, wdata (ready always high)
//
// one tick transaction per cycle unless an untaken result waits; its result is registered, shown the next cycle
// debounce, prescaler and relay phase all update in the cycle the tick is taken
// a waiting result does not block the tick side if it is taken in the same cycle
// rst is synchronous: phase idle, histories clear, mode 0, delay 0, 61 ticks a second
module multifunction_time_relay #(
  parameter int HISTORY_LEN = 10
) (
  input logic         clk,
  input logic         rst,
  mtr_tick_if.sink    tick,
  mtr_result_if.source result,
  mtr_cfg_if.sink     cfg
);

  mtr_pkg::cfg_t    cfg_reg;
  mtr_pkg::result_t res_next;
  mtr_pkg::result_t res_reg;
  logic             out_valid;
  logic             accept;
  logic             cfg_wr;
  logic             mode_wr;
  logic             start_level;
  logic             stop_level;

  assign tick.ready = !out_valid || result.ready;
  assign accept     = tick.valid && tick.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_wr     = cfg.valid && cfg.ready;
  assign mode_wr    = cfg_wr && (cfg.reg_index == mtr_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.mode             <= mtr_pkg::MODE_ON_DELAY;
      cfg_reg.delay_seconds    <= 4'd0;
      cfg_reg.ticks_per_second <= mtr_pkg::TPS_RESET;
    end else if (cfg_wr) begin
      case (cfg.reg_index)
        mtr_pkg::REG_MODE:  cfg_reg.mode             <= mtr_pkg::mode_t'(cfg.wdata[1:0]);
        mtr_pkg::REG_DELAY: cfg_reg.delay_seconds    <= cfg.wdata[3:0];
        mtr_pkg::REG_TPS:   cfg_reg.ticks_per_second <= cfg.wdata;
        default: ;
      endcase
    end
  end

  mtr_debounce #(.HISTORY_LEN(HISTORY_LEN)) u_start_db (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .raw        (tick.start_pressed),
    .level_next (start_level)
  );

  mtr_debounce #(.HISTORY_LEN(HISTORY_LEN)) u_stop_db (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .raw        (tick.stop_pressed),
    .level_next (stop_level)
  );

  mtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .en       (accept),
    .start    (start_level),
    .stop     (stop_level),
    .mode_wr  (mode_wr),
    .cfg      (cfg_reg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_reg <= res_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.relay_on         = res_reg.relay_on;
  assign result.off_delay_active = res_reg.off_delay_active;

endmodule
